/* design/item_id_histogram_macros.svh */
// Assertion macros shared by the item id histogram RTL.
`ifndef ITEM_ID_HISTOGRAM_MACROS_SVH
`define ITEM_ID_HISTOGRAM_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while the reset is asserted.
`define IH_ASSERT(lbl, clk_, rstn_, prop_, msg_) \
	lbl: assert property (@(posedge clk_) disable iff (!rstn_) prop_) else $error(msg_);

// Clocked check that also holds during reset.
`define IH_ASSERT_ALWAYS(lbl, clk_, prop_, msg_) \
	lbl: assert property (@(posedge clk_) prop_) else $error(msg_);

`else

`define IH_ASSERT(lbl, clk_, rstn_, prop_, msg_)
`define IH_ASSERT_ALWAYS(lbl, clk_, prop_, msg_)

`endif

`endif

/* design/ihist_pkg.sv */
// Constants and command codes for the item id histogram.
`timescale 1ns / 1ps

package ihist_pkg;

	localparam int NUM_BINS    = 1024;
	localparam int COUNT_WIDTH = 32;
	localparam int BIN_AW      = $clog2(NUM_BINS);
	localparam int ID_W        = 16;
	localparam int CMD_W       = 2;
	localparam int OUT_W       = 32;

	localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
	localparam logic [BIN_AW-1:0]      LAST_BIN  = BIN_AW'(NUM_BINS - 1);
	localparam logic [ID_W:0]          BIN_LIMIT = (ID_W + 1)'(NUM_BINS);

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [BIN_AW-1:0]      bin_addr_t;

endpackage

/* design/ihist_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ihist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/item_id_histogram.sv */
// Top level of the item id histogram: request handling, counter update and result register.
`timescale 1ns / 1ps
`include "item_id_histogram_macros.svh"

// Item id histogram. Keeps NUM_BINS saturating counters of COUNT_WIDTH bits in
// one synchronous RAM. Each request carries a command in s_tuser and an id in
// s_tdata. A count request bumps the bin named by the id and returns nothing;
// a read request returns the bin's count on m_tdata with the sticky range flag
// on m_tuser (the flag covers every out-of-range count id since the previous
// read, that read's own id included, and a read clears it); a clear request
// zeroes every bin. Count ids at or above NUM_BINS touch no bin. Timing: the
// RAM is read in the accept cycle and written back in the next, with a one-deep
// forward path for back-to-back hits on the same bin, so count requests go in
// at one per cycle while no clear walk or full result register holds s_tready
// low. A read, clear or unused command holds s_tready low for the cycle after
// it is taken, so no request follows a read straight away. A clear walks the
// RAM one bin per cycle with s_tready low; after reset the same walk runs
// once, and s_tready stays low until it has zeroed the last bin. A result
// waits in an output register; s_tready also falls while that register is
// full and not drained.
module item_id_histogram
	import ihist_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // [15:0] item_id
	input  logic [1:0]       s_tuser,   // [1:0] command
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // [31:0] bin_count
	output logic             m_tuser    // [0] range_error
);

	// request side
	logic      accept;
	logic      out_free;
	logic      s1_busy;

	// stage 1: RAM data is back, update and write
	logic             valid_s1;
	logic [CMD_W-1:0] cmd_s1;
	bin_addr_t        addr_s1;
	logic             in_range_s1;

	// last counter write, forwarded into the next request
	logic      fwd_valid_q;
	bin_addr_t fwd_addr_q;
	count_t    fwd_data_q;

	// clear walk
	logic      clearing_q;
	bin_addr_t clr_idx_q;
	logic      clr_done;

	logic      range_seen_q;

	// result register
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic             m_tuser_q;

	// RAM ports
	logic      ram_we;
	bin_addr_t ram_waddr;
	count_t    ram_wdata;
	count_t    ram_rdata;

	count_t    cur_count;
	count_t    next_count;
	logic      cnt_we;
	logic      is_read_s1;
	logic      is_clear_s1;

	assign out_free = !m_tvalid_q || m_tready;
	// anything but a count in stage 1 may touch the result register or start a clear
	assign s1_busy  = valid_s1 && (cmd_s1 != CMD_COUNT);
	assign s_tready = !clearing_q && !s1_busy && out_free;
	assign accept   = s_tvalid && s_tready;

	ihist_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (s_tdata[BIN_AW-1:0]),
		.rdata (ram_rdata)
	);

	// stage 1 decode
	always_comb begin
		cnt_we      = 1'b0;
		is_read_s1  = 1'b0;
		is_clear_s1 = 1'b0;
		if (valid_s1) begin
			unique case (cmd_s1)
				CMD_COUNT: cnt_we      = in_range_s1;
				CMD_READ:  is_read_s1  = 1'b1;
				CMD_CLEAR: is_clear_s1 = 1'b1;
				default:   ;
			endcase
		end
	end

	// RAM read may predate the previous cycle's write to the same bin
	assign cur_count  = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : ram_rdata;
	assign next_count = (cur_count == CNT_MAX) ? cur_count : cur_count + 1'b1;

	// clear walk and counter update never overlap: a clear holds off new requests
	assign ram_we    = cnt_we || clearing_q;
	assign ram_waddr = clearing_q ? clr_idx_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : next_count;

	assign clr_done  = clearing_q && (clr_idx_q == LAST_BIN);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			fwd_valid_q  <= 1'b0;
			clearing_q   <= 1'b1;   // power-up walk zeroes the RAM
			clr_idx_q    <= '0;
			range_seen_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			valid_s1    <= accept;
			fwd_valid_q <= cnt_we;

			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_done) begin
					clearing_q <= 1'b0;
					clr_idx_q  <= '0;
				end
			end else if (is_clear_s1) begin
				clearing_q <= 1'b1;
				clr_idx_q  <= '0;
			end

			if (valid_s1 && (cmd_s1 == CMD_COUNT) && !in_range_s1) begin
				range_seen_q <= 1'b1;
			end else if (is_read_s1) begin
				range_seen_q <= 1'b0;
			end

			if (is_read_s1) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= s_tuser;
			addr_s1     <= s_tdata[BIN_AW-1:0];
			in_range_s1 <= ({1'b0, s_tdata} < BIN_LIMIT);
		end
		if (cnt_we) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= next_count;
		end
		if (is_read_s1) begin
			m_tdata_q <= in_range_s1 ? OUT_W'(cur_count) : '0;
			m_tuser_q <= range_seen_q || !in_range_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// no request slips in during the clear walk
	`IH_ASSERT(a_no_accept_clearing, clk, arst_n, clearing_q |-> !s_tready, "request in clear")
	// a read reaching stage 1 always finds the result register empty
	`IH_ASSERT(a_result_slot_free, clk, arst_n, is_read_s1 |-> !m_tvalid_q, "result overwritten")
	// the walk stops right after the last bin
	`IH_ASSERT(a_clear_ends, clk, arst_n, clr_done |=> !clearing_q, "walk ran past the last bin")
	// counter update and clear write never share a cycle
	`IH_ASSERT(a_no_write_clash, clk, arst_n, clearing_q |-> !cnt_we, "count during clear")

endmodule
